// ----- sv/gda_pkg.sv -----
// ----------------------------------------------------------------------------
// Gregorian date arithmetic package
// Shared types, calendar constants and the leap-year, month-length and clamp helpers.
// ----------------------------------------------------------------------------
package gda_pkg;

    // Field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int TERM_W  = 16;
    localparam int COUNT_W = 22;
    localparam int ORDER_W = 2;

    // Calendar limits
    localparam logic [YEAR_W-1:0]  MAX_YEAR        = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [DAY_W-1:0]   LAST_DAY_DEC    = 5'd31;

    // Ordinal day number: p*365 + p/4 - p/100 + p/400, p = year - 1
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    // floor(p / 100) = (p * 5243) >> 19 for p below 2^14
    localparam logic [12:0] RECIP_100     = 13'd5243;
    localparam int          RECIP_100_SH  = 19;
    // floor(n / 12) = (n * 43691) >> 19 for n below 2^16
    localparam logic [15:0] RECIP_12      = 16'd43691;
    localparam int          RECIP_12_SH   = 19;

    // y divisible by 25 iff (y * inverse of 25 mod 2^14) mod 2^14 <= (2^14-1)/25
    localparam logic [YEAR_W-1:0] INV_25     = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV_25_LIM = 14'd655;

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_ADD_DAYS   = 2'd0,
        FUNC_ADD_MONTHS = 2'd1,
        FUNC_DIFF       = 2'd2,
        FUNC_COMPARE    = 2'd3
    } t_func;

    // Order codes
    typedef enum logic [ORDER_W-1:0] {
        ORDER_EQUAL  = 2'd0,
        ORDER_BEFORE = 2'd1,
        ORDER_AFTER  = 2'd2
    } t_order;

    // Gregorian rule: leap = div4 and (not div100 or div400),
    // with div100 = div4 and div25, div400 = div16 and div25
    function automatic logic f_is_leap(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] prod;
        logic                div25;
        begin
            prod  = {{YEAR_W{1'b0}}, y} * {{YEAR_W{1'b0}}, INV_25};
            div25 = (prod[YEAR_W-1:0] <= DIV_25_LIM);
            return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
        end
    endfunction

    // Days in a month; codes outside 1..12 read as 31
    function automatic logic [DAY_W-1:0] f_month_len(input logic leap,
                                                     input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        begin
            case (m) inside
                4'd2:                   len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
                default:                len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // Clamp a raw year into 1..MAX_YEAR
    function automatic logic [YEAR_W-1:0] f_clamp_year(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] r;
        begin
            if (y == '0) begin
                r = {{(YEAR_W-1){1'b0}}, 1'b1};
            end else if (y > MAX_YEAR) begin
                r = MAX_YEAR;
            end else begin
                r = y;
            end
            return r;
        end
    endfunction

    // Clamp a raw month into 1..12
    function automatic logic [MONTH_W-1:0] f_clamp_month(input logic [MONTH_W-1:0] m);
        logic [MONTH_W-1:0] r;
        begin
            if (m == '0) begin
                r = 4'd1;
            end else if (m > MONTHS_PER_YEAR) begin
                r = MONTHS_PER_YEAR;
            end else begin
                r = m;
            end
            return r;
        end
    endfunction

endpackage

// ----- sv/gregorian_date_arithmetic.sv -----
// ----------------------------------------------------------------------------
// Gregorian date arithmetic unit
// Adds days or months to a date, counts days between two dates, or compares
// them, with one shared month-length unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_* takes one request per transaction: tuser is the
//   operation, tdata carries dates A and B and the term count. Master channel
//   m_axis_* returns one result per request: date, leap flag, day count and
//   order in tdata, the error flag in tuser.
//   One request is worked on at a time; s_axis_tready is high only while the
//   sequencer is idle. After acceptance both dates are clamped and the
//   operation is dispatched: compare, add months with a zero term, and
//   difference with A before B go straight to the final state; add months
//   takes an add step and, unless the year overflows, a day-clamp step;
//   difference forms the ordinal of each date in turn; add days moves the
//   date on until the term lands, and the month-length unit steps one month per cycle.
//   The result sits in an output register, so the next request is accepted
//   while a finished result waits. If the receiver stalls and a second
//   result is done, the sequencer holds in its final state until the first
//   transaction completes.
//   Reset (synchronous, active low) returns the sequencer to idle and drops
//   any pending result.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // a_year[13:0], a_month[17:14], a_day[22:18], b_year[36:23],
    // b_month[40:37], b_day[45:41], term_count[61:46], zero[63:62]
    input  logic [63:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    // Result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // res_year[13:0], res_month[17:14], res_day[22:18], res_leap[23],
    // day_count[45:24], order[47:46]
    output logic [47:0] m_axis_tdata,
    // error[0]
    output logic [0:0]  m_axis_tuser
);

    localparam int YW = gda_pkg::YEAR_W;
    localparam int MW = gda_pkg::MONTH_W;
    localparam int DW = gda_pkg::DAY_W;
    localparam int NW = gda_pkg::TERM_W;
    localparam int CW = gda_pkg::COUNT_W;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_CLAMP_A  = 11'b000_0000_0010,
        ST_CLAMP_B  = 11'b000_0000_0100,
        ST_DISPATCH = 11'b000_0000_1000,
        ST_DAYS     = 11'b000_0001_0000,
        ST_MADD     = 11'b000_0010_0000,
        ST_MCLAMP   = 11'b000_0100_0000,
        ST_OMUL     = 11'b000_1000_0000,
        ST_OSUM     = 11'b001_0000_0000,
        ST_OMON     = 11'b010_0000_0000,
        ST_FINISH   = 11'b100_0000_0000
    } t_state;

    t_state              r_state, n_state;
    gda_pkg::t_func      r_func;
    logic [YW-1:0]       r_ay, r_by;
    logic [MW-1:0]       r_am, r_bm, r_mi;
    logic [DW-1:0]       r_ad, r_bd;
    logic [NW-1:0]       r_n;
    logic [12:0]         r_q;
    logic                r_side;
    logic [CW-1:0]       r_m365, r_acc, r_ord_a, r_count;
    logic [6:0]          r_q100;
    gda_pkg::t_order     r_order;
    logic                r_err;
    logic [47:0]         r_o_data;
    logic                r_o_err;
    logic                r_o_valid;

    logic [YW-1:0]       s_leap_y;
    logic [MW-1:0]       s_ml_m;
    logic                s_leap;
    logic [DW-1:0]       s_ml;
    logic                s_a_lt_b, s_a_eq_b;
    logic [DW-1:0]       s_left;
    logic                s_days_fit, s_days_ovf;
    logic [31:0]         s_q12p;
    logic [NW-1:0]       s_q12, s_rem;
    logic [DW-1:0]       s_m0;
    logic                s_mcarry;
    logic [MW-1:0]       s_mnew;
    logic [YW:0]         s_ny;
    logic                s_movf;
    logic [YW-1:0]       s_oy, s_p;
    logic [MW-1:0]       s_om;
    logic [DW-1:0]       s_od;
    logic [22:0]         s_m365p;
    logic [26:0]         s_q100p;
    logic                s_out_free;

    // Shared month-length unit: pick the year and month for this step
    always_comb begin
        s_leap_y = ((r_state == ST_CLAMP_B) || ((r_state == ST_OMON) && r_side)) ? r_by : r_ay;
        if (r_state == ST_CLAMP_B) begin
            s_ml_m = r_bm;
        end else if (r_state == ST_OMON) begin
            s_ml_m = r_mi;
        end else begin
            s_ml_m = r_am;
        end
        s_leap = gda_pkg::f_is_leap(s_leap_y);
        s_ml   = gda_pkg::f_month_len(s_leap, s_ml_m);
    end

    // Date order
    assign s_a_lt_b = {r_ay, r_am, r_ad} < {r_by, r_bm, r_bd};
    assign s_a_eq_b = {r_ay, r_am, r_ad} == {r_by, r_bm, r_bd};

    // Day stepping: finish inside this month or move to the next one
    assign s_left     = s_ml - r_ad;
    assign s_days_fit = (r_n <= NW'(s_left));
    assign s_days_ovf = (r_am == gda_pkg::MONTHS_PER_YEAR) && (r_ay == gda_pkg::MAX_YEAR);

    // Month addition: quotient and remainder of the term by twelve
    assign s_q12p   = {16'd0, r_n} * {16'd0, gda_pkg::RECIP_12};
    assign s_q12    = {r_q[12:0], 3'b000} + {1'b0, r_q[12:0], 2'b00};
    assign s_rem    = r_n - s_q12;
    assign s_m0     = DW'(r_am) - 5'd1 + DW'(s_rem[MW-1:0]);
    assign s_mcarry = (s_m0 >= DW'(gda_pkg::MONTHS_PER_YEAR));
    assign s_mnew   = s_mcarry ? MW'(s_m0 - DW'(gda_pkg::MONTHS_PER_YEAR)) + 4'd1
                               : MW'(s_m0) + 4'd1;
    assign s_ny     = {1'b0, r_ay} + (YW+1)'(r_q) + (YW+1)'(s_mcarry);
    assign s_movf   = (s_ny > (YW+1)'(gda_pkg::MAX_YEAR));

    // Ordinal day number of the selected date
    assign s_oy    = r_side ? r_by : r_ay;
    assign s_om    = r_side ? r_bm : r_am;
    assign s_od    = r_side ? r_bd : r_ad;
    assign s_p     = s_oy - 14'd1;
    assign s_m365p = {9'd0, s_p} * {14'd0, gda_pkg::DAYS_PER_YEAR};
    assign s_q100p = {13'd0, s_p} * {14'd0, gda_pkg::RECIP_100};

    assign s_out_free = !r_o_valid || m_axis_tready;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_CLAMP_A;
            end
            ST_CLAMP_A: n_state = ST_CLAMP_B;
            ST_CLAMP_B: n_state = ST_DISPATCH;
            ST_DISPATCH: begin
                unique case (r_func)
                    gda_pkg::FUNC_ADD_DAYS:   n_state = ST_DAYS;
                    gda_pkg::FUNC_ADD_MONTHS: n_state = (r_n == '0) ? ST_FINISH : ST_MADD;
                    gda_pkg::FUNC_DIFF:       n_state = s_a_lt_b ? ST_FINISH : ST_OMUL;
                    default:                  n_state = ST_FINISH;
                endcase
            end
            ST_DAYS: begin
                if (s_days_fit || s_days_ovf) n_state = ST_FINISH;
            end
            ST_MADD:   n_state = s_movf ? ST_FINISH : ST_MCLAMP;
            ST_MCLAMP: n_state = ST_FINISH;
            ST_OMUL:   n_state = ST_OSUM;
            ST_OSUM:   n_state = ST_OMON;
            ST_OMON: begin
                if (r_mi >= s_om) n_state = r_side ? ST_FINISH : ST_OMUL;
            end
            ST_FINISH: begin
                if (s_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_FINISH) && s_out_free) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                // Capture the request with years, months and zero days clamped
                if (s_axis_tvalid) begin
                    r_func  <= gda_pkg::t_func'(s_axis_tuser);
                    r_ay    <= gda_pkg::f_clamp_year(s_axis_tdata[13:0]);
                    r_am    <= gda_pkg::f_clamp_month(s_axis_tdata[17:14]);
                    r_ad    <= (s_axis_tdata[22:18] == '0) ? 5'd1 : s_axis_tdata[22:18];
                    r_by    <= gda_pkg::f_clamp_year(s_axis_tdata[36:23]);
                    r_bm    <= gda_pkg::f_clamp_month(s_axis_tdata[40:37]);
                    r_bd    <= (s_axis_tdata[45:41] == '0) ? 5'd1 : s_axis_tdata[45:41];
                    r_n     <= s_axis_tdata[61:46];
                    r_count <= '0;
                    r_order <= gda_pkg::ORDER_EQUAL;
                    r_err   <= 1'b0;
                    r_side  <= 1'b0;
                end
            end
            ST_CLAMP_A: begin
                if (r_ad > s_ml) r_ad <= s_ml;
            end
            ST_CLAMP_B: begin
                if (r_bd > s_ml) r_bd <= s_ml;
            end
            ST_DISPATCH: begin
                r_q <= s_q12p[31:gda_pkg::RECIP_12_SH];
                case (r_func)
                    gda_pkg::FUNC_DIFF: begin
                        if (s_a_lt_b) r_err <= 1'b1;
                    end
                    gda_pkg::FUNC_COMPARE: begin
                        if (s_a_lt_b) begin
                            r_order <= gda_pkg::ORDER_BEFORE;
                        end else if (s_a_eq_b) begin
                            r_order <= gda_pkg::ORDER_EQUAL;
                        end else begin
                            r_order <= gda_pkg::ORDER_AFTER;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DAYS: begin
                // Advance one month, land inside the current one, or saturate on overflow
                if (s_days_fit) begin
                    r_ad <= r_ad + DW'(r_n);
                end else if (s_days_ovf) begin
                    r_ay  <= gda_pkg::MAX_YEAR;
                    r_am  <= gda_pkg::MONTHS_PER_YEAR;
                    r_ad  <= gda_pkg::LAST_DAY_DEC;
                    r_err <= 1'b1;
                end else begin
                    r_n  <= r_n - NW'(s_left) - 16'd1;
                    r_ad <= 5'd1;
                    if (r_am == gda_pkg::MONTHS_PER_YEAR) begin
                        r_am <= 4'd1;
                        r_ay <= r_ay + 14'd1;
                    end else begin
                        r_am <= r_am + 4'd1;
                    end
                end
            end
            ST_MADD: begin
                if (s_movf) begin
                    r_ay  <= gda_pkg::MAX_YEAR;
                    r_am  <= gda_pkg::MONTHS_PER_YEAR;
                    r_ad  <= gda_pkg::LAST_DAY_DEC;
                    r_err <= 1'b1;
                end else begin
                    r_ay <= s_ny[YW-1:0];
                    r_am <= s_mnew;
                end
            end
            ST_MCLAMP: begin
                // Clamp the day to the target month
                if (r_ad > s_ml) r_ad <= s_ml;
            end
            ST_OMUL: begin
                r_m365 <= s_m365p[CW-1:0];
                r_q100 <= s_q100p[25:gda_pkg::RECIP_100_SH];
                r_mi   <= 4'd1;
            end
            ST_OSUM: begin
                r_acc <= r_m365 + CW'(s_p[YW-1:2]) - CW'(r_q100)
                       + CW'(r_q100[6:2]) + CW'(s_od);
            end
            ST_OMON: begin
                // Accumulate the lengths of the months before the date
                if (r_mi < s_om) begin
                    r_acc <= r_acc + CW'(s_ml);
                    r_mi  <= r_mi + 4'd1;
                end else if (!r_side) begin
                    r_ord_a <= r_acc;
                    r_side  <= 1'b1;
                end else begin
                    r_count <= r_ord_a - r_acc;
                end
            end
            ST_FINISH: begin
                if (s_out_free) begin
                    r_o_data <= {r_order, r_count, s_leap, r_ad, r_am, r_ay};
                    r_o_err  <= r_err;
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_err;

    // A request is taken only from idle: the cycle after one, no other is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while busy");

    // An errored result never carries a day count
    a_err_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[45:24] == '0))
        else $error("error result with nonzero day count");

    // Result dates stay on the calendar
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[17:14] != '0) && (m_axis_tdata[17:14] <= 4'd12)
                           && (m_axis_tdata[22:18] != '0) && (m_axis_tdata[13:0] != '0)))
        else $error("result date out of range");

    // Day stepping never leaves the current month's length
    a_day_in_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DAYS) |-> (r_ad <= s_ml))
        else $error("working day beyond month length");

endmodule
